// ===== src/rbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Rijndael cipher package
// Shared types, codes, tables and round functions for the Rijndael block.
// ----------------------------------------------------------------------------
package rbcm_pkg;

  localparam int BLOCK_BITS = 256;
  localparam int RK_ROWS    = 15;

  localparam logic [1:0] MODE_ENC     = 2'd0;
  localparam logic [1:0] MODE_DEC     = 2'd1;
  localparam logic [1:0] MODE_LOAD    = 2'd2;
  localparam logic [1:0] MODE_RESTORE = 2'd3;

  localparam logic [1:0] CHAIN_ECB = 2'd0;
  localparam logic [1:0] CHAIN_CBC = 2'd1;
  localparam logic [1:0] CHAIN_CFB = 2'd2;

  localparam logic [2:0] REG_KEY0       = 3'd0;
  localparam logic [2:0] REG_KEY1       = 3'd1;
  localparam logic [2:0] REG_KEY2       = 3'd2;
  localparam logic [2:0] REG_KEY3       = 3'd3;
  localparam logic [2:0] REG_GIVEN      = 3'd4;
  localparam logic [2:0] REG_KEY_SIZE   = 3'd5;
  localparam logic [2:0] REG_BLOCK_SIZE = 3'd6;
  localparam logic [2:0] REG_CHAINING   = 3'd7;

  localparam logic [7:0] RED_POLY  = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [2047:0] SBOX_BITS = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX_BITS = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  typedef struct packed {
    logic [255:0] key;
    logic [1:0]   bsel;
    logic [3:0]   nb;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   given;
    logic [1:0]   chaining;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] mode;
    logic       loaded;
    logic       exp_start;
    logic       exp_step;
    logic       exp_init;
    logic       exp_rot;
    logic       exp_sub;
    logic [2:0] exp_col;
    logic [3:0] exp_row;
    logic       exp_wr;
    logic [3:0] rk_addr;
    logic       ld_state;
    logic       add_key;
    logic       round;
    logic       last;
    logic       finish;
  } cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] x, input logic inv);
    if (inv) begin
      return INV_SBOX_BITS[{~x, 3'b000} +: 8];
    end
    return SBOX_BITS[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? RED_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24], 1'b0), sbox(w[23:16], 1'b0), sbox(w[15:8], 1'b0),
            sbox(w[7:0], 1'b0)};
  endfunction

  function automatic logic [255:0] sub_all(input logic [255:0] s, input logic inv);
    logic [255:0] r;
    for (int i = 0; i < 32; i++) begin
      r[8*i +: 8] = sbox(s[8*i +: 8], inv);
    end
    return r;
  endfunction

  function automatic logic [255:0] shift_case(input logic [255:0] s, input int nbc,
                                              input int k1, input int k2, input int k3);
    logic [255:0] r;
    int k;
    int src;
    r = s;
    for (int row = 1; row < 4; row++) begin
      k = (row == 1) ? k1 : ((row == 2) ? k2 : k3);
      for (int c = 0; c < 8; c++) begin
        if (c < nbc) begin
          src = c + k;
          if (src >= nbc) begin
            src = src - nbc;
          end
          r[255 - 8*(4*c + row) -: 8] = s[255 - 8*(4*src + row) -: 8];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [255:0] shift_rows(input logic [255:0] s, input logic [1:0] bsel,
                                              input logic inv);
    case (bsel)
      2'd0:    return inv ? shift_case(s, 4, 3, 2, 1) : shift_case(s, 4, 1, 2, 3);
      2'd1:    return inv ? shift_case(s, 6, 5, 4, 3) : shift_case(s, 6, 1, 2, 3);
      default: return inv ? shift_case(s, 8, 7, 5, 4) : shift_case(s, 8, 1, 3, 4);
    endcase
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m0 [4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      a[i]  = w[31 - 8*i -: 8];
      x2[i] = xt(a[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
      if (inv) begin
        m0[i] = x8[i] ^ x4[i] ^ x2[i];
        m1[i] = x8[i] ^ x2[i] ^ a[i];
        m2[i] = x8[i] ^ x4[i] ^ a[i];
        m3[i] = x8[i] ^ a[i];
      end else begin
        m0[i] = x2[i];
        m1[i] = x2[i] ^ a[i];
        m2[i] = a[i];
        m3[i] = a[i];
      end
    end
    r[31:24] = m0[0] ^ m1[1] ^ m2[2] ^ m3[3];
    r[23:16] = m3[0] ^ m0[1] ^ m1[2] ^ m2[3];
    r[15:8]  = m2[0] ^ m3[1] ^ m0[2] ^ m1[3];
    r[7:0]   = m1[0] ^ m2[1] ^ m3[2] ^ m0[3];
    return r;
  endfunction

  function automatic logic [255:0] mix_all(input logic [255:0] s, input logic inv);
    logic [255:0] r;
    for (int c = 0; c < 8; c++) begin
      r[255 - 32*c -: 32] = mix_col(s[255 - 32*c -: 32], inv);
    end
    return r;
  endfunction

  function automatic logic [255:0] block_mask(input logic [1:0] bsel);
    case (bsel)
      2'd0:    return {{128{1'b1}}, {128{1'b0}}};
      2'd1:    return {{192{1'b1}}, {64{1'b0}}};
      default: return {256{1'b1}};
    endcase
  endfunction

endpackage

// ===== src/rbcm_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one block and its operation mode.
// ----------------------------------------------------------------------------
interface rbcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] in_word0;
  logic [63:0] in_word1;
  logic [63:0] in_word2;
  logic [63:0] in_word3;

  modport source (output valid, mode, in_word0, in_word1, in_word2, in_word3,
                  input ready);
  modport sink (input valid, mode, in_word0, in_word1, in_word2, in_word3,
                output ready);
endinterface

// ===== src/rbcm_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one result block and its status.
// ----------------------------------------------------------------------------
interface rbcm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word0;
  logic [63:0] out_word1;
  logic [63:0] out_word2;
  logic [63:0] out_word3;
  logic        status;

  modport source (output valid, out_word0, out_word1, out_word2, out_word3, status,
                  input ready);
  modport sink (input valid, out_word0, out_word1, out_word2, out_word3, status,
                output ready);
endinterface

// ===== src/rijndael_block_cipher_modes.sv =====
// ----------------------------------------------------------------------------
// Rijndael block cipher with ECB, CBC and CFB chaining
// Top level: APB configuration, controller and datapath.
// ----------------------------------------------------------------------------
// Encrypt/decrypt: a registered row read of the round key store, then one round
// per cycle through the shared round unit (Nr = 10..14). After a key, given or
// size write, the first cipher item also runs key expansion first, one key word
// per cycle, into the round key store.
// Load, restore and not-loaded items skip the rounds. One item at a time.
// Reset clears the chain registers and flags; the round key store is not cleared.
module rijndael_block_cipher_modes (
  input  logic        clk,
  input  logic        rst,
  rbcm_in_if.sink     in_ch,
  rbcm_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  rbcm_pkg::cfg_t cfg;
  rbcm_pkg::cmd_t cmd;
  logic           key_change;

  rbcm_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .key_change (key_change)
  );

  rbcm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .key_change (key_change),
    .in_valid   (in_ch.valid),
    .in_mode    (in_ch.mode),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd)
  );

  rbcm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_word0  (in_ch.in_word0),
    .in_word1  (in_ch.in_word1),
    .in_word2  (in_ch.in_word2),
    .in_word3  (in_ch.in_word3),
    .out_word0 (out_ch.out_word0),
    .out_word1 (out_ch.out_word1),
    .out_word2 (out_ch.out_word2),
    .out_word3 (out_ch.out_word3),
    .status    (out_ch.status)
  );

endmodule

// ===== src/rbcm_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file for key, sizes and chaining, with decoded settings.
// ----------------------------------------------------------------------------
module rbcm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output rbcm_pkg::cfg_t      cfg,
  output logic                key_change
);

  logic [63:0] key_word [4];
  logic [5:0]  given_raw;
  logic [1:0]  key_size;
  logic [1:0]  block_size;
  logic [1:0]  chaining;
  logic [2:0]  idx;
  logic        wr;
  logic [1:0]  bs;
  logic [1:0]  ks;
  logic [1:0]  mx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_word[i] <= 64'd0;
      end
      given_raw  <= 6'd16;
      key_size   <= 2'd0;
      block_size <= 2'd0;
      chaining   <= rbcm_pkg::CHAIN_ECB;
    end else if (wr) begin
      unique case (idx)
        rbcm_pkg::REG_KEY0:       key_word[0] <= pwdata;
        rbcm_pkg::REG_KEY1:       key_word[1] <= pwdata;
        rbcm_pkg::REG_KEY2:       key_word[2] <= pwdata;
        rbcm_pkg::REG_KEY3:       key_word[3] <= pwdata;
        rbcm_pkg::REG_GIVEN:      given_raw   <= pwdata[5:0];
        rbcm_pkg::REG_KEY_SIZE:   key_size    <= pwdata[1:0];
        rbcm_pkg::REG_BLOCK_SIZE: block_size  <= pwdata[1:0];
        rbcm_pkg::REG_CHAINING:   chaining    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  assign key_change = wr && (idx != rbcm_pkg::REG_CHAINING);

  always_comb begin
    unique case (idx)
      rbcm_pkg::REG_KEY0:       prdata = key_word[0];
      rbcm_pkg::REG_KEY1:       prdata = key_word[1];
      rbcm_pkg::REG_KEY2:       prdata = key_word[2];
      rbcm_pkg::REG_KEY3:       prdata = key_word[3];
      rbcm_pkg::REG_GIVEN:      prdata = {58'd0, given_raw};
      rbcm_pkg::REG_KEY_SIZE:   prdata = {62'd0, key_size};
      rbcm_pkg::REG_BLOCK_SIZE: prdata = {62'd0, block_size};
      rbcm_pkg::REG_CHAINING:   prdata = {62'd0, chaining};
      default:                  prdata = 64'd0;
    endcase
  end

  assign bs = (block_size == 2'd3) ? 2'd2 : block_size;
  assign ks = (key_size == 2'd3) ? 2'd2 : key_size;
  assign mx = (bs > ks) ? bs : ks;

  always_comb begin
    cfg.key      = {key_word[0], key_word[1], key_word[2], key_word[3]};
    cfg.bsel     = bs;
    cfg.nb       = {1'b0, bs, 1'b0} + 4'd4;
    cfg.nk       = {1'b0, ks, 1'b0} + 4'd4;
    cfg.nr       = {1'b0, mx, 1'b0} + 4'd10;
    cfg.given    = (given_raw == 6'd0) ? 6'd1 :
                   ((given_raw > 6'd32) ? 6'd32 : given_raw);
    cfg.chaining = (chaining == 2'd3) ? rbcm_pkg::CHAIN_ECB : chaining;
  end

endmodule

// ===== src/rbcm_dp.sv =====
// ----------------------------------------------------------------------------
// Cipher datapath
// Key schedule, round key store, round unit, chain registers and result.
// ----------------------------------------------------------------------------
module rbcm_dp (
  input  logic           clk,
  input  logic           rst,
  input  rbcm_pkg::cfg_t cfg,
  input  rbcm_pkg::cmd_t cmd,
  input  logic [63:0]    in_word0,
  input  logic [63:0]    in_word1,
  input  logic [63:0]    in_word2,
  input  logic [63:0]    in_word3,
  output logic [63:0]    out_word0,
  output logic [63:0]    out_word1,
  output logic [63:0]    out_word2,
  output logic [63:0]    out_word3,
  output logic           status
);

  logic [255:0] rk_mem [rbcm_pkg::RK_ROWS];
  logic [255:0] rk_q;
  logic [255:0] rowbuf;
  logic [255:0] rowdata;
  logic [31:0]  win [8];
  logic [4:0]   src;
  logic [7:0]   rcon;
  logic [4:0]   p [5];
  logic [31:0]  kw_init;
  logic [31:0]  t;
  logic [31:0]  new_word;
  logic [2:0]   far_idx;

  logic [255:0] blk;
  logic [255:0] st;
  logic [255:0] ch;
  logic [255:0] saved;
  logic [255:0] mask;
  logic [255:0] init_st;
  logic [255:0] enc_sh;
  logic [255:0] enc_round;
  logic [255:0] dec_t;
  logic [255:0] dec_round;
  logic [255:0] res;
  logic [255:0] out_data;
  logic         use_dec;
  logic         chained;
  logic         crypt_ok;

  function automatic logic [4:0] wrap_inc(input logic [4:0] v, input logic [5:0] given);
    return (({1'b0, v} + 6'd1) == given) ? 5'd0 : (v + 5'd1);
  endfunction

  always_comb begin
    p[0] = src;
    for (int i = 1; i < 5; i++) begin
      p[i] = wrap_inc(p[i-1], cfg.given);
    end
    for (int i = 0; i < 4; i++) begin
      kw_init[31 - 8*i -: 8] = cfg.key[255 - 8*p[i] -: 8];
    end
    far_idx = 3'(cfg.nk - 4'd1);
    t = win[0];
    if (cmd.exp_init) begin
      new_word = kw_init;
    end else if (cmd.exp_rot) begin
      new_word = win[far_idx] ^ rbcm_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'd0};
    end else if (cmd.exp_sub) begin
      new_word = win[far_idx] ^ rbcm_pkg::sub_word(t);
    end else begin
      new_word = win[far_idx] ^ t;
    end
    rowdata = rowbuf;
    for (int c = 0; c < 8; c++) begin
      if (cmd.exp_col == 3'(c)) begin
        rowdata[255 - 32*c -: 32] = new_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      src  <= 5'd0;
      rcon <= rbcm_pkg::RCON_INIT;
    end else if (cmd.exp_step) begin
      if (cmd.exp_init) begin
        src <= p[4];
      end
      if (cmd.exp_rot) begin
        rcon <= rbcm_pkg::xt(rcon);
      end
      win[0] <= new_word;
      for (int i = 1; i < 8; i++) begin
        win[i] <= win[i-1];
      end
      rowbuf <= rowdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step && cmd.exp_wr) begin
      rk_mem[cmd.exp_row] <= rowdata;
    end
    rk_q <= rk_mem[cmd.rk_addr];
  end

  assign mask     = rbcm_pkg::block_mask(cfg.bsel);
  assign use_dec  = (cmd.mode == rbcm_pkg::MODE_DEC) && (cfg.chaining != rbcm_pkg::CHAIN_CFB);
  assign chained  = (cfg.chaining == rbcm_pkg::CHAIN_CBC) ||
                    (cfg.chaining == rbcm_pkg::CHAIN_CFB);
  assign crypt_ok = cmd.loaded &&
                    ((cmd.mode == rbcm_pkg::MODE_ENC) || (cmd.mode == rbcm_pkg::MODE_DEC));

  always_comb begin
    if (cfg.chaining == rbcm_pkg::CHAIN_CFB) begin
      init_st = ch;
    end else if ((cfg.chaining == rbcm_pkg::CHAIN_CBC) && (cmd.mode == rbcm_pkg::MODE_ENC)) begin
      init_st = blk ^ ch;
    end else begin
      init_st = blk;
    end
    enc_sh    = rbcm_pkg::shift_rows(rbcm_pkg::sub_all(st, 1'b0), cfg.bsel, 1'b0);
    enc_round = (cmd.last ? enc_sh : rbcm_pkg::mix_all(enc_sh, 1'b0)) ^ rk_q;
    dec_t     = rbcm_pkg::sub_all(rbcm_pkg::shift_rows(st, cfg.bsel, 1'b1), 1'b1) ^ rk_q;
    dec_round = cmd.last ? dec_t : rbcm_pkg::mix_all(dec_t, 1'b1);
    if ((cfg.chaining == rbcm_pkg::CHAIN_CBC) && (cmd.mode == rbcm_pkg::MODE_DEC)) begin
      res = st ^ ch;
    end else if (cfg.chaining == rbcm_pkg::CHAIN_CFB) begin
      res = st ^ blk;
    end else begin
      res = st;
    end
    out_data = crypt_ok ? (res & mask) : 256'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      blk <= {in_word0, in_word1, in_word2, in_word3};
    end
    if (cmd.ld_state) begin
      st <= init_st;
    end else if (cmd.add_key) begin
      st <= st ^ rk_q;
    end else if (cmd.round) begin
      st <= use_dec ? dec_round : enc_round;
    end
    if (cmd.finish) begin
      {out_word0, out_word1, out_word2, out_word3} <= out_data;
      status <= !cmd.loaded && (cmd.mode != rbcm_pkg::MODE_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch    <= 256'd0;
      saved <= 256'd0;
    end else if (cmd.finish) begin
      if (cmd.mode == rbcm_pkg::MODE_LOAD) begin
        ch    <= blk & mask;
        saved <= blk & mask;
      end else if (cmd.loaded && (cmd.mode == rbcm_pkg::MODE_RESTORE)) begin
        ch <= saved;
      end else if (crypt_ok && chained) begin
        if (cmd.mode == rbcm_pkg::MODE_ENC) begin
          ch <= (ch & ~mask) | (res & mask);
        end else begin
          ch <= (ch & ~mask) | (blk & mask);
        end
      end
    end
  end

endmodule

// ===== src/rbcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cipher controller
// Sequences key expansion, round iterations and result transfer.
// ----------------------------------------------------------------------------
module rbcm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  rbcm_pkg::cfg_t cfg,
  input  logic           key_change,
  input  logic           in_valid,
  input  logic [1:0]     in_mode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rbcm_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXPAND = 3'd1;
  localparam logic [2:0] S_KEY0   = 3'd2;
  localparam logic [2:0] S_ADD0   = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] mode_q;
  logic       loaded;
  logic       expanded;
  logic [3:0] rnd;
  logic [2:0] exp_col;
  logic [3:0] exp_row;
  logic [2:0] kcnt;
  logic       exp_init;
  logic       accept;
  logic       fin_go;
  logic       col_end;
  logic       k_end;
  logic       exp_done;
  logic       last;
  logic       use_dec;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);
  assign col_end  = ({1'b0, exp_col} == (cfg.nb - 4'd1));
  assign k_end    = ({1'b0, kcnt} == (cfg.nk - 4'd1));
  assign exp_done = (state == S_EXPAND) && col_end && (exp_row == cfg.nr);
  assign last     = (rnd == (cfg.nr + 4'd1));
  assign use_dec  = (mode_q == rbcm_pkg::MODE_DEC) && (cfg.chaining != rbcm_pkg::CHAIN_CFB);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((in_mode == rbcm_pkg::MODE_LOAD) || (in_mode == rbcm_pkg::MODE_RESTORE) ||
              !loaded) begin
            state_next = S_FIN;
          end else if (!expanded) begin
            state_next = S_EXPAND;
          end else begin
            state_next = S_KEY0;
          end
        end
      end
      S_EXPAND: begin
        if (exp_done) begin
          state_next = S_KEY0;
        end
      end
      S_KEY0:  state_next = S_ADD0;
      S_ADD0:  state_next = S_ROUND;
      S_ROUND: begin
        if (last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loaded    <= 1'b0;
      expanded  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (key_change) begin
        expanded <= 1'b0;
      end else if (exp_done) begin
        expanded <= 1'b1;
      end
      if (fin_go && (mode_q == rbcm_pkg::MODE_LOAD)) begin
        loaded <= 1'b1;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= in_mode;
      rnd      <= 4'd0;
      exp_col  <= 3'd0;
      exp_row  <= 4'd0;
      kcnt     <= 3'd0;
      exp_init <= 1'b1;
    end else if (state == S_EXPAND) begin
      exp_col <= col_end ? 3'd0 : (exp_col + 3'd1);
      exp_row <= col_end ? (exp_row + 4'd1) : exp_row;
      kcnt    <= k_end ? 3'd0 : (kcnt + 3'd1);
      if (k_end) begin
        exp_init <= 1'b0;
      end
    end else if ((state == S_KEY0) || (state == S_ADD0) || ((state == S_ROUND) && !last)) begin
      rnd <= rnd + 4'd1;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.mode      = mode_q;
    cmd.loaded    = loaded;
    cmd.exp_start = accept;
    cmd.exp_step  = (state == S_EXPAND);
    cmd.exp_init  = exp_init;
    cmd.exp_rot   = !exp_init && (kcnt == 3'd0);
    cmd.exp_sub   = !exp_init && (cfg.nk == 4'd8) && (kcnt == 3'd4);
    cmd.exp_col   = exp_col;
    cmd.exp_row   = exp_row;
    cmd.exp_wr    = col_end;
    if (rnd > cfg.nr) begin
      cmd.rk_addr = 4'd0;
    end else begin
      cmd.rk_addr = use_dec ? (cfg.nr - rnd) : rnd;
    end
    cmd.ld_state  = (state == S_KEY0);
    cmd.add_key   = (state == S_ADD0);
    cmd.round     = (state == S_ROUND);
    cmd.last      = last;
    cmd.finish    = fin_go;
  end

  a_fin_out: assert property (@(posedge clk) disable iff (rst) fin_go |=> out_valid)
    else $error("result register not marked full after finish");
  a_rnd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> ({1'b0, rnd} <= ({1'b0, cfg.nr} + 5'd1)))
    else $error("round counter past last round");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("result dropped while output register full");
  a_exp_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXPAND) |-> (exp_row <= cfg.nr))
    else $error("key expansion row out of range");

endmodule

// ===== dv/tb_rijndael_block_cipher_modes.sv =====
// ----------------------------------------------------------------------------
// Rijndael block cipher modes testbench
// Drives encrypt, decrypt, load and restore transfers through the input
// channel under many key, block and chaining settings, predicts each result
// with an independent cipher model, and checks every output transfer.
// ----------------------------------------------------------------------------
module tb_rijndael_block_cipher_modes;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int KEY_STORE   = 120;

  typedef logic [7:0]  blk_t [32];
  typedef logic [63:0] quad_t [4];
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] w0, w1, w2, w3;
  } block_req_t;
  typedef struct packed {
    logic [63:0] w0, w1, w2, w3;
    logic        status;
  } cipher_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  rbcm_in_if  in_ch ();
  rbcm_out_if out_ch ();

  rijndael_block_cipher_modes u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  block_req_t  block_queue [$];
  cipher_res_t expected_results [$];
  int          send_idle_pct = 37;
  int          recv_idle_pct = 65;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Cipher state as seen by the checker.
  logic [63:0] key_q [4];
  logic [5:0]  given_q;
  logic [1:0]  ksz_q, bsz_q, chn_q;
  logic [31:0] round_key [KEY_STORE];
  quad_t       chain_q, init_chain_q;
  bit          expanded_q, loaded_q;
  int          rot_tab [3][6] = '{'{1, 2, 3, 3, 2, 1}, '{1, 2, 3, 5, 4, 3},
                                  '{1, 3, 4, 7, 5, 4}};

  function automatic int size_sel(logic [1:0] v);
    return (v == 2'd3) ? 2 : int'(v);
  endfunction

  function automatic int blk_cols();
    return 4 + 2 * size_sel(bsz_q);
  endfunction

  function automatic int key_cols();
    return 4 + 2 * size_sel(ksz_q);
  endfunction

  function automatic int round_count();
    return ((blk_cols() > key_cols()) ? blk_cols() : key_cols()) + 6;
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    return rbcm_pkg::SBOX_BITS[2047 - 8 * int'(x) -: 8];
  endfunction

  function automatic logic [7:0] inv_sub(logic [7:0] x);
    return rbcm_pkg::INV_SBOX_BITS[2047 - 8 * int'(x) -: 8];
  endfunction

  function automatic logic [7:0] times2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? rbcm_pkg::RED_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = times2(a);
    end
    return r;
  endfunction

  function automatic logic [31:0] rk_read(int i);
    return (i < KEY_STORE) ? round_key[i] : 32'h0;
  endfunction

  function automatic logic [31:0] sub4(logic [31:0] w);
    return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
  endfunction

  function automatic void expand_round_keys();
    logic [7:0]  kb [32];
    logic [7:0]  rc;
    logic [31:0] t;
    int nk, total, given, src;
    nk = key_cols();
    total = blk_cols() * (round_count() + 1);
    given = (given_q == 0) ? 1 : ((given_q > 32) ? 32 : int'(given_q));
    src = 0;
    rc = rbcm_pkg::RCON_INIT;
    for (int i = 0; i < 4 * nk; i++) begin
      kb[i] = key_q[(src >> 3) & 3][63 - 8 * (src & 7) -: 8];
      src = (src + 1) % given;
    end
    for (int i = 0; i < nk; i++) begin
      round_key[i] = {kb[4*i], kb[4*i+1], kb[4*i+2], kb[4*i+3]};
    end
    for (int i = nk; i < total; i++) begin
      t = rk_read(i - 1);
      if (i % nk == 0) begin
        t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = times2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub4(t);
      end
      if (i < KEY_STORE) round_key[i] = rk_read(i - nk) ^ t;
    end
    expanded_q = 1'b1;
  endfunction

  function automatic blk_t to_bytes(quad_t w, int n);
    blk_t b;
    for (int i = 0; i < 32; i++) begin
      b[i] = (i < n) ? w[i >> 3][63 - 8 * (i & 7) -: 8] : 8'h00;
    end
    return b;
  endfunction

  function automatic quad_t to_words(blk_t b, int n);
    quad_t w;
    w = '{default: '0};
    for (int i = 0; i < n; i++) w[i >> 3][63 - 8 * (i & 7) -: 8] = b[i];
    return w;
  endfunction

  function automatic blk_t add_round_key(blk_t s, int rd, int nb);
    logic [31:0] w;
    for (int c = 0; c < nb; c++) begin
      w = rk_read(rd * nb + c);
      for (int r = 0; r < 4; r++) s[4*c+r] ^= w[31 - 8 * r -: 8];
    end
    return s;
  endfunction

  function automatic blk_t rotate_rows(blk_t s, int nb, int base);
    logic [7:0] tmp [8];
    int k;
    for (int r = 1; r < 4; r++) begin
      k = rot_tab[size_sel(bsz_q)][base + r - 1];
      for (int c = 0; c < nb; c++) tmp[c] = s[4 * ((c + k) % nb) + r];
      for (int c = 0; c < nb; c++) s[4*c+r] = tmp[c];
    end
    return s;
  endfunction

  function automatic blk_t mix_columns(blk_t s, int nb, logic [7:0] m0, logic [7:0] m1,
                                       logic [7:0] m2, logic [7:0] m3);
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < nb; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      s[4*c]   = gf_mul(a0, m0) ^ gf_mul(a1, m1) ^ gf_mul(a2, m2) ^ gf_mul(a3, m3);
      s[4*c+1] = gf_mul(a0, m3) ^ gf_mul(a1, m0) ^ gf_mul(a2, m1) ^ gf_mul(a3, m2);
      s[4*c+2] = gf_mul(a0, m2) ^ gf_mul(a1, m3) ^ gf_mul(a2, m0) ^ gf_mul(a3, m1);
      s[4*c+3] = gf_mul(a0, m1) ^ gf_mul(a1, m2) ^ gf_mul(a2, m3) ^ gf_mul(a3, m0);
    end
    return s;
  endfunction

  function automatic blk_t encipher(blk_t s);
    int nb, nr;
    nb = blk_cols();
    nr = round_count();
    s = add_round_key(s, 0, nb);
    for (int rd = 1; rd <= nr; rd++) begin
      for (int i = 0; i < 4 * nb; i++) s[i] = fwd_sub(s[i]);
      s = rotate_rows(s, nb, 0);
      if (rd < nr) s = mix_columns(s, nb, 8'd2, 8'd3, 8'd1, 8'd1);
      s = add_round_key(s, rd, nb);
    end
    return s;
  endfunction

  function automatic blk_t decipher(blk_t s);
    int nb, nr;
    nb = blk_cols();
    nr = round_count();
    s = add_round_key(s, nr, nb);
    for (int rd = nr - 1; rd >= 0; rd--) begin
      s = rotate_rows(s, nb, 3);
      for (int i = 0; i < 4 * nb; i++) s[i] = inv_sub(s[i]);
      s = add_round_key(s, rd, nb);
      if (rd > 0) s = mix_columns(s, nb, 8'd14, 8'd11, 8'd13, 8'd9);
    end
    return s;
  endfunction

  function automatic cipher_res_t cipher_step(logic [1:0] mode, quad_t din);
    cipher_res_t r;
    blk_t  blk, ch, res;
    quad_t w;
    int    n;
    n = 4 * blk_cols();
    r = '0;
    blk = to_bytes(din, n);
    res = '{default: '0};
    if (mode == rbcm_pkg::MODE_LOAD) begin
      init_chain_q = to_words(blk, n);
      chain_q = init_chain_q;
      loaded_q = 1'b1;
      return r;
    end
    if (!loaded_q) begin
      r.status = 1'b1;
      return r;
    end
    if (mode == rbcm_pkg::MODE_RESTORE) begin
      chain_q = init_chain_q;
      return r;
    end
    if (!expanded_q) expand_round_keys();
    ch = to_bytes(chain_q, 32);
    if (chn_q == rbcm_pkg::CHAIN_CBC) begin
      if (mode == rbcm_pkg::MODE_ENC) begin
        for (int i = 0; i < n; i++) res[i] = blk[i] ^ ch[i];
        res = encipher(res);
        for (int i = 0; i < n; i++) ch[i] = res[i];
      end else begin
        res = decipher(blk);
        for (int i = 0; i < n; i++) begin
          res[i] ^= ch[i];
          ch[i] = blk[i];
        end
      end
    end else if (chn_q == rbcm_pkg::CHAIN_CFB) begin
      res = encipher(ch);
      for (int i = 0; i < n; i++) begin
        res[i] ^= blk[i];
        ch[i] = (mode == rbcm_pkg::MODE_ENC) ? res[i] : blk[i];
      end
    end else begin
      res = (mode == rbcm_pkg::MODE_ENC) ? encipher(blk) : decipher(blk);
    end
    chain_q = to_words(ch, 32);
    w = to_words(res, n);
    r.w0 = w[0]; r.w1 = w[1]; r.w2 = w[2]; r.w3 = w[3];
    return r;
  endfunction

  always @(posedge clk) begin
    quad_t      din;
    block_req_t req;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        din = '{in_ch.in_word0, in_ch.in_word1, in_ch.in_word2, in_ch.in_word3};
        expected_results.push_back(cipher_step(in_ch.mode, din));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (block_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = block_queue.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= req.mode;
          in_ch.in_word0 <= req.w0;
          in_ch.in_word1 <= req.w1;
          in_ch.in_word2 <= req.w2;
          in_ch.in_word3 <= req.w3;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cipher_res_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_word0, out_ch.out_word1, out_ch.out_word2, out_ch.out_word3,
               out_ch.status};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got.w0 !== want.w0 || got.w1 !== want.w1 || got.w2 !== want.w2 ||
              got.w3 !== want.w3 || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result error: expected %h %h %h %h st %b", want.w0, want.w1,
                       want.w2, want.w3, want.status);
              $display("              actual   %h %h %h %h st %b", got.w0, got.w1,
                       got.w2, got.w3, got.status);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("rijndael_block_cipher_modes: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rbcm_pkg::REG_GIVEN:      given_q = value[5:0];
      rbcm_pkg::REG_KEY_SIZE:   ksz_q = value[1:0];
      rbcm_pkg::REG_BLOCK_SIZE: bsz_q = value[1:0];
      rbcm_pkg::REG_CHAINING:   chn_q = value[1:0];
      default:                  key_q[idx] = value;
    endcase
    if (idx != rbcm_pkg::REG_CHAINING) expanded_q = 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (block_queue.size() != 0 || in_ch.valid || expected_results.size() != 0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_block(logic [1:0] mode, logic [63:0] w0, logic [63:0] w1,
                                     logic [63:0] w2, logic [63:0] w3);
    block_queue.push_back('{mode, w0, w1, w2, w3});
  endfunction

  function automatic void push_random_block();
    logic [1:0] mode;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) mode = 2'($urandom_range(3));
    else if (pick < 23) mode = rbcm_pkg::MODE_LOAD;
    else if (pick < 28) mode = rbcm_pkg::MODE_RESTORE;
    else mode = pick[0] ? rbcm_pkg::MODE_ENC : rbcm_pkg::MODE_DEC;
    push_block(mode, rand64(), rand64(), rand64(), rand64());
  endfunction

  initial begin
    logic [63:0] ones;
    logic [63:0] given_pick [7];
    ones = '1;
    given_pick = '{64'd0, 64'd1, 64'd16, 64'd32, 64'd33, 64'd63, 64'd7};
    key_q = '{default: '0};
    given_q = 6'd16;
    ksz_q = '0;
    bsz_q = '0;
    chn_q = rbcm_pkg::CHAIN_ECB;
    chain_q = '{default: '0};
    init_chain_q = '{default: '0};
    expanded_q = 1'b0;
    loaded_q = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = rbcm_pkg::MODE_ENC;
    in_ch.in_word0 = '0;
    in_ch.in_word1 = '0;
    in_ch.in_word2 = '0;
    in_ch.in_word3 = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    push_block(rbcm_pkg::MODE_ENC, rand64(), rand64(), rand64(), rand64());
    push_block(rbcm_pkg::MODE_DEC, ones, ones, ones, ones);
    push_block(rbcm_pkg::MODE_RESTORE, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_LOAD, ones, ones, ones, ones);
    push_block(rbcm_pkg::MODE_ENC, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_ENC, ones, ones, ones, ones);
    push_block(rbcm_pkg::MODE_DEC, ones, ones, ones, ones);
    push_block(rbcm_pkg::MODE_RESTORE, ones, ones, ones, ones);
    push_block(rbcm_pkg::MODE_DEC, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_LOAD, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_ENC, rand64(), rand64(), rand64(), rand64());
    drain();
    repeat (40) @(posedge clk);
    reg_write(rbcm_pkg::REG_KEY0, ones);
    reg_write(rbcm_pkg::REG_KEY1, '0);
    reg_write(rbcm_pkg::REG_CHAINING, 64'(rbcm_pkg::CHAIN_CBC));
    push_block(rbcm_pkg::MODE_LOAD, rand64(), rand64(), rand64(), rand64());
    push_block(rbcm_pkg::MODE_ENC, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_DEC, ones, ones, ones, ones);
    push_block(rbcm_pkg::MODE_RESTORE, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_DEC, rand64(), rand64(), rand64(), rand64());
    drain();
    repeat (40) @(posedge clk);
    reg_write(rbcm_pkg::REG_CHAINING, 64'(rbcm_pkg::CHAIN_CFB));
    push_block(rbcm_pkg::MODE_ENC, ones, ones, ones, ones);
    push_block(rbcm_pkg::MODE_DEC, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_RESTORE, '0, '0, '0, '0);
    push_block(rbcm_pkg::MODE_DEC, rand64(), rand64(), rand64(), rand64());

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      repeat (40) @(posedge clk);
      send_idle_pct = (ph < 4) ? 37 : ((ph < 8) ? 65 : 0);
      recv_idle_pct = (ph < 4) ? 65 : ((ph < 8) ? 37 : 0);
      reg_write(rbcm_pkg::REG_KEY0, rand64());
      reg_write(rbcm_pkg::REG_KEY1, rand64());
      reg_write(rbcm_pkg::REG_KEY2, (ph == 1) ? '0 : ((ph == 2) ? ones : rand64()));
      reg_write(rbcm_pkg::REG_KEY3, (ph == 1) ? '0 : ((ph == 2) ? ones : rand64()));
      reg_write(rbcm_pkg::REG_GIVEN, (ph == 1) ? 64'd0 : ((ph == 2) ? 64'd63 :
                given_pick[$urandom_range(6)]));
      reg_write(rbcm_pkg::REG_KEY_SIZE, (ph == 1) ? 64'd0 : ((ph == 2) ? 64'd3 :
                64'($urandom_range(3))));
      reg_write(rbcm_pkg::REG_BLOCK_SIZE, (ph == 1) ? 64'd0 : ((ph == 2) ? 64'd3 :
                64'($urandom_range(3))));
      reg_write(rbcm_pkg::REG_CHAINING, (ph == 1) ? 64'(rbcm_pkg::CHAIN_ECB) :
                ((ph == 2) ? 64'd3 : 64'($urandom_range(3))));
      for (int i = 0; i < 100; i++) begin
        if (ph == 5 && i == 50) drain();
        push_random_block();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("rijndael_block_cipher_modes: match");
    end else begin
      $display("rijndael_block_cipher_modes: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rbcm_pkg.sv
src/rbcm_in_if.sv
src/rbcm_out_if.sv
src/rbcm_cfg.sv
src/rbcm_dp.sv
src/rbcm_ctrl.sv
src/rijndael_block_cipher_modes.sv
dv/tb_rijndael_block_cipher_modes.sv
